[rtl/ftzr_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and helpers of the flat triangle z-buffer raster core
// no dependencies; imported by every module of the block

package ftzr_pkg;

  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 128;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 40;
  localparam int COLOR_W     = 8;
  localparam int DEPTH_W     = 16;
  localparam int COUNT_W     = 15;
  // signed row numbers: ceil of a 12.4 position plus margin
  localparam int ROW_W       = 14;
  localparam int ARITH_W     = 64;

  localparam logic [DEPTH_W-1:0] DEPTH_FAR = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;

  typedef enum logic [2:0] {
    CMD_LOAD  = 3'd0,
    CMD_DRAW  = 3'd1,
    CMD_CLEAR = 3'd2,
    CMD_FILL  = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef struct packed {
    logic                      start;
    logic                      is_div;
    logic signed [ARITH_W-1:0] a;
    logic signed [ARITH_W-1:0] b;
  } md_req_t;

  typedef struct packed {
    logic                      busy;
    logic                      done;
    logic signed [ARITH_W-1:0] result;
  } md_rsp_t;

  // arithmetic shift right that truncates toward zero
  function automatic logic signed [ARITH_W-1:0] shr_trunc(input logic signed [ARITH_W-1:0] v,
                                                          input int unsigned sh);
    logic signed [ARITH_W-1:0] bias;
    bias = (64'sd1 <<< sh) - 64'sd1;
    return v[ARITH_W-1] ? ((v + bias) >>> sh) : (v >>> sh);
  endfunction

endpackage

[rtl/ftzr_ram.sv]
`timescale 1ns / 1ps
// generic simple dual-port ram, one write port and one registered read port
// uses ftzr_pkg for default sizes

module ftzr_ram
  import ftzr_pkg::*;
#(
  parameter int WIDTH = COLOR_W,
  parameter int DEPTH = DEF_SCREEN_WIDTH * DEF_SCREEN_HEIGHT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/ftzr_muldiv.sv]
`timescale 1ns / 1ps
// shared iterative unit: 64-bit wrapping multiply (shift-add, early exit)
// and 64-bit signed divide by a positive divisor, truncating; uses ftzr_pkg

module ftzr_muldiv
  import ftzr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  md_req_t req,
  output md_rsp_t rsp
);

  logic               busy_r;
  logic               div_r;
  logic               done_r;
  logic               neg_r;
  logic [6:0]         cnt_r;
  logic [ARITH_W-1:0] acc_r;
  logic [ARITH_W-1:0] mc_r;
  logic [ARITH_W-1:0] mp_r;
  logic [ARITH_W:0]   rem_r;
  logic [ARITH_W-1:0] res_r;

  logic [ARITH_W:0]   rem_sh;
  logic               ge;
  logic [ARITH_W-1:0] quo_nxt;

  assign rem_sh  = {rem_r[ARITH_W-1:0], mp_r[ARITH_W-1]};
  assign ge      = rem_sh >= {1'b0, mc_r};
  assign quo_nxt = {mp_r[ARITH_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        div_r  <= req.is_div;
        cnt_r  <= '0;
        acc_r  <= '0;
        rem_r  <= '0;
        neg_r  <= req.is_div & req.a[ARITH_W-1];
        if (req.is_div) begin
          mp_r <= req.a[ARITH_W-1] ? (~req.a + 64'd1) : req.a;
          mc_r <= req.b;
        end else begin
          mp_r <= req.b;
          mc_r <= req.a;
        end
      end else if (busy_r) begin
        if (div_r) begin
          rem_r <= ge ? (rem_sh - {1'b0, mc_r}) : rem_sh;
          mp_r  <= quo_nxt;
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd63) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
            res_r  <= neg_r ? (~quo_nxt + 64'd1) : quo_nxt;
          end
        end else if (mp_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          res_r  <= acc_r;
        end else begin
          if (mp_r[0]) begin
            acc_r <= acc_r + mc_r;
          end
          mc_r <= {mc_r[ARITH_W-2:0], 1'b0};
          mp_r <= {1'b0, mp_r[ARITH_W-1:1]};
        end
      end
    end
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

[rtl/flat_triangle_zbuffer_raster_core.sv]
`timescale 1ns / 1ps
// top level of the flat triangle z-buffer raster core
// depends on ftzr_pkg, ftzr_ram and ftzr_muldiv

// Flat-shaded triangle rasterizer with a color store and a depth store of
// SCREEN_WIDTH x SCREEN_HEIGHT entries (row major), both in single-write,
// single-read memories with a registered read port. Every input transfer
// gives exactly one result transfer. One command is in flight at a time; the
// next command is taken while the previous result waits on the output.
// After reset, and for each depth clear or color fill command, a sweep writes
// one entry per cycle over all SCREEN_WIDTH*SCREEN_HEIGHT entries (16384 at
// the default size); no command is taken during the reset sweep. A draw first
// sorts the vertices by y and tests for rejection, then the shared iterative
// multiply/divide unit sets up each triangle half and each span (one divide
// plus one multiply), and the depth store then does read-compare-write at one
// pixel per cycle.

module flat_triangle_zbuffer_raster_core
  import ftzr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration: color_level_enable
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,
  // input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // command[2:0] vertex_slot[4:3] pos_x[20:5] pos_y[36:21] vertex_depth[54:37]
  // fill_color[62:55] light[70:63] pixel_index[84:71], zero pad above
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // pixel_color[7:0] pixel_depth[23:8] pixels_written[38:24] skipped[39]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int StoreSize = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AddrW     = $clog2(StoreSize);
  localparam int ColW      = $clog2(SCREEN_WIDTH + 1);
  localparam logic signed [ROW_W-1:0]   HeightS = ROW_W'(SCREEN_HEIGHT);
  localparam logic signed [ARITH_W-1:0] WidthA  = ARITH_W'(SCREEN_WIDTH);

  typedef enum logic [10:0] {
    ST_CLEAR = 11'b000_0000_0001,
    ST_IDLE  = 11'b000_0000_0010,
    ST_READ  = 11'b000_0000_0100,
    ST_SORT  = 11'b000_0000_1000,
    ST_CHECK = 11'b000_0001_0000,
    ST_PART  = 11'b000_0010_0000,
    ST_OP    = 11'b000_0100_0000,
    ST_ROW   = 11'b000_1000_0000,
    ST_PIX   = 11'b001_0000_0000,
    ST_NEXT  = 11'b010_0000_0000,
    ST_DONE  = 11'b100_0000_0000
  } state_t;

  // operations run on the shared multiply/divide unit
  typedef enum logic [3:0] {
    OP_SX02, OP_SZ02, OP_SXA, OP_SZA, OP_AX, OP_AZ, OP_BX, OP_BZ, OP_DZS, OP_ZST
  } op_t;

  // ---------------------------------------------------------------- fields
  logic [2:0]                in_cmd;
  logic [1:0]                in_slot;
  logic signed [15:0]        in_x;
  logic signed [15:0]        in_y;
  logic signed [17:0]        in_z;
  logic [COLOR_W-1:0]        in_fc;
  logic signed [7:0]         in_light;
  logic [13:0]               in_pix;

  assign in_cmd   = in_tdata[2:0];
  assign in_slot  = in_tdata[4:3];
  assign in_x     = in_tdata[20:5];
  assign in_y     = in_tdata[36:21];
  assign in_z     = in_tdata[54:37];
  assign in_fc    = in_tdata[62:55];
  assign in_light = in_tdata[70:63];
  assign in_pix   = in_tdata[84:71];

  // ---------------------------------------------------------------- registers
  state_t                    state_r, state_nxt;
  logic                      level_en_r;
  logic signed [15:0]        vx_r [3];
  logic signed [15:0]        vy_r [3];
  logic signed [17:0]        vz_r [3];
  logic signed [15:0]        wx_r [3];          // working copy, sorted by y
  logic signed [15:0]        wy_r [3];
  logic signed [17:0]        wz_r [3];
  logic [1:0]                sort_step_r;
  logic [COLOR_W-1:0]        draw_color_r;
  logic [AddrW-1:0]          clr_idx_r;
  logic                      clr_color_r, clr_depth_r, clr_cmd_r;
  logic [COLOR_W-1:0]        clr_val_r;
  logic                      rd_ok_r;
  op_t                       op_r;
  logic                      op_go_r;
  logic                      part_r;            // 0 upper half, 1 lower half
  logic                      swap_r;
  logic signed [ROW_W-1:0]   r_r, last_r;
  logic signed [ARITH_W-1:0] sx02_r, sz02_r, sxa_r, sza_r;
  logic signed [ARITH_W-1:0] ax_r, az_r, bx_r, bz_r;
  logic signed [ARITH_W-1:0] dzs_r, zacc_r;
  logic [ColW-1:0]           col_r, right_r;
  logic [AddrW-1:0]          idx_r;
  // depth compare stage
  logic                      pv_r, pok_r;
  logic [AddrW-1:0]          paddr_r;
  logic [DEPTH_W-1:0]        pd_r;
  logic [COUNT_W-1:0]        cnt_r;
  logic                      skip_r;
  logic [COLOR_W-1:0]        res_color_r;
  logic [DEPTH_W-1:0]        res_depth_r;
  logic                      out_valid_r;
  logic [OUT_TDATA_W-1:0]    out_data_r;

  // ---------------------------------------------------------------- memories
  logic                      col_we, dep_we;
  logic [AddrW-1:0]          col_waddr, dep_waddr, col_raddr, dep_raddr;
  logic [COLOR_W-1:0]        col_wdata, col_rdata;
  logic [DEPTH_W-1:0]        dep_wdata, dep_rdata;

  ftzr_ram #(.WIDTH(COLOR_W), .DEPTH(StoreSize)) u_color_ram (
    .clk, .we(col_we), .waddr(col_waddr), .wdata(col_wdata),
    .raddr(col_raddr), .rdata(col_rdata)
  );

  ftzr_ram #(.WIDTH(DEPTH_W), .DEPTH(StoreSize)) u_depth_ram (
    .clk, .we(dep_we), .waddr(dep_waddr), .wdata(dep_wdata),
    .raddr(dep_raddr), .rdata(dep_rdata)
  );

  // ---------------------------------------------------------------- mul/div unit
  md_req_t md_req;
  md_rsp_t md_rsp;

  ftzr_muldiv u_muldiv (.clk, .rst_n, .req(md_req), .rsp(md_rsp));

  // ---------------------------------------------------------------- helpers
  function automatic logic signed [ROW_W-1:0] ceil16(input logic signed [15:0] y);
    logic signed [16:0] t;
    t = 17'(y) + 17'sd15;
    return ROW_W'(t >>> 4);
  endfunction

  function automatic logic signed [ROW_W-1:0] smax0(input logic signed [ROW_W-1:0] v);
    return (v < 0) ? '0 : v;
  endfunction

  function automatic logic signed [ROW_W-1:0] smin(input logic signed [ROW_W-1:0] a,
                                                   input logic signed [ROW_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  logic                      in_acc, out_free;
  logic signed [ROW_W-1:0]   cy0, cy1, cy2, up_first, up_last;
  logic                      reject;
  logic [1:0]                sp, sq;
  logic signed [ARITH_W-1:0] s_a, s_b;
  logic signed [ARITH_W-1:0] span_a, span_b, span_za, span_zb, ca, cb, start_s, right_s;
  logic                      row_end, span_skip;
  logic signed [ARITH_W-1:0] dsum;
  logic                      pix_issue, pass;
  logic signed [9:0]         lo_sum;
  logic [3:0]                lo_sat;
  logic                      clr_last;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign cy0      = ceil16(wy_r[0]);
  assign cy1      = ceil16(wy_r[1]);
  assign cy2      = ceil16(wy_r[2]);
  assign reject   = (cy2 < 0) || ((cy2 - cy0) <= ROW_W'(1)) || (cy0 >= HeightS);
  assign up_first = smax0(cy0);
  assign up_last  = smin(cy1 - ROW_W'(1), HeightS - ROW_W'(1));

  // compare-exchange pair of the current sort step
  assign sp = (sort_step_r == 2'd1) ? 2'd1 : 2'd0;
  assign sq = sp + 2'd1;

  // offsets in 1/16 pixel from the starting vertex of each edge
  assign s_a = (ARITH_W'(r_r) <<< 4) - ARITH_W'(part_r ? wy_r[1] : wy_r[0]);
  assign s_b = (ARITH_W'(r_r) <<< 4) - ARITH_W'(wy_r[0]);

  // current span, left to right
  assign span_a  = swap_r ? bx_r : ax_r;
  assign span_b  = swap_r ? ax_r : bx_r;
  assign span_za = swap_r ? bz_r : az_r;
  assign span_zb = swap_r ? az_r : bz_r;
  assign ca      = (span_a + 64'sd65535) >>> 16;
  assign cb      = (span_b + 64'sd65535) >>> 16;
  assign start_s = (ca < 0) ? '0 : ca;
  assign right_s = (cb > WidthA) ? WidthA : cb;
  assign row_end   = r_r > last_r;
  assign span_skip = (span_b <= span_a) || (start_s >= WidthA) || (cb <= 0);

  // light adjust of the low nibble
  assign lo_sum = $signed({6'b0, in_fc[3:0]}) + {{2{in_light[7]}}, in_light};
  assign lo_sat = (lo_sum < 0) ? 4'd0 : ((lo_sum > 10'sd15) ? 4'd15 : lo_sum[3:0]);

  // pixel pipe: issue a depth read, compare in the next cycle
  assign pix_issue = (state_r == ST_PIX) && (col_r != right_r);
  assign dsum      = zacc_r + 64'sd32768;
  assign pass      = pv_r && pok_r && (pd_r <= dep_rdata);
  assign clr_last  = clr_idx_r == AddrW'(StoreSize - 1);

  // ---------------------------------------------------------------- memory ports
  always_comb begin
    col_raddr = AddrW'(in_pix);
    dep_raddr = (state_r == ST_IDLE) ? AddrW'(in_pix) : idx_r;
    if (state_r == ST_CLEAR) begin
      col_we    = clr_color_r;
      col_waddr = clr_idx_r;
      col_wdata = clr_val_r;
      dep_we    = clr_depth_r;
      dep_waddr = clr_idx_r;
      dep_wdata = DEPTH_FAR;
    end else begin
      col_we    = pass;
      col_waddr = paddr_r;
      col_wdata = draw_color_r;
      dep_we    = pass;
      dep_waddr = paddr_r;
      dep_wdata = pd_r;
    end
  end

  // ---------------------------------------------------------------- unit request
  always_comb begin
    md_req.start  = (state_r == ST_OP) && op_go_r;
    md_req.is_div = 1'b1;
    md_req.a      = '0;
    md_req.b      = 64'sd1;
    case (op_r)
      OP_SX02: begin
        md_req.a = (ARITH_W'(wx_r[2]) - ARITH_W'(wx_r[0])) <<< 16;
        md_req.b = ARITH_W'(wy_r[2]) - ARITH_W'(wy_r[0]);
      end
      OP_SZ02: begin
        md_req.a = (ARITH_W'(wz_r[2]) - ARITH_W'(wz_r[0])) <<< 20;
        md_req.b = ARITH_W'(wy_r[2]) - ARITH_W'(wy_r[0]);
      end
      OP_SXA: begin
        md_req.a = part_r ? ((ARITH_W'(wx_r[2]) - ARITH_W'(wx_r[1])) <<< 16)
                          : ((ARITH_W'(wx_r[1]) - ARITH_W'(wx_r[0])) <<< 16);
        md_req.b = part_r ? (ARITH_W'(wy_r[2]) - ARITH_W'(wy_r[1]))
                          : (ARITH_W'(wy_r[1]) - ARITH_W'(wy_r[0]));
      end
      OP_SZA: begin
        md_req.a = part_r ? ((ARITH_W'(wz_r[2]) - ARITH_W'(wz_r[1])) <<< 20)
                          : ((ARITH_W'(wz_r[1]) - ARITH_W'(wz_r[0])) <<< 20);
        md_req.b = part_r ? (ARITH_W'(wy_r[2]) - ARITH_W'(wy_r[1]))
                          : (ARITH_W'(wy_r[1]) - ARITH_W'(wy_r[0]));
      end
      OP_AX: begin
        md_req.is_div = 1'b0;
        md_req.a      = sxa_r;
        md_req.b      = s_a;
      end
      OP_AZ: begin
        md_req.is_div = 1'b0;
        md_req.a      = sza_r;
        md_req.b      = s_a;
      end
      OP_BX: begin
        md_req.is_div = 1'b0;
        md_req.a      = sx02_r;
        md_req.b      = s_b;
      end
      OP_BZ: begin
        md_req.is_div = 1'b0;
        md_req.a      = sz02_r;
        md_req.b      = s_b;
      end
      OP_DZS: begin
        md_req.a = (span_zb - span_za) <<< 16;
        md_req.b = span_b - span_a;
      end
      OP_ZST: begin
        md_req.is_div = 1'b0;
        md_req.a      = dzs_r;
        md_req.b      = (ARITH_W'(col_r) <<< 16) - span_a;
      end
      default: begin
        md_req.is_div = 1'b1;
      end
    endcase
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = clr_cmd_r ? ST_DONE : ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            CMD_DRAW:               state_nxt = (in_fc == '0) ? ST_DONE : ST_SORT;
            CMD_CLEAR, CMD_FILL:    state_nxt = ST_CLEAR;
            CMD_READ:               state_nxt = ST_READ;
            default:                state_nxt = ST_DONE;
          endcase
        end
      end
      ST_READ:  state_nxt = ST_DONE;
      ST_SORT:  if (sort_step_r == 2'd2) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = reject ? ST_DONE : ST_OP;
      ST_PART: begin
        if (!part_r) begin
          if (up_first <= up_last) state_nxt = ST_OP;
        end else if ((cy1 >= HeightS) || (cy2 == cy1)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_OP;
        end
      end
      ST_OP: begin
        if (md_rsp.done) begin
          case (op_r)
            OP_SZ02: state_nxt = ST_PART;
            OP_BZ:   state_nxt = ST_ROW;
            OP_ZST:  state_nxt = ST_PIX;
            default: state_nxt = ST_OP;
          endcase
        end
      end
      ST_ROW: begin
        if (row_end)        state_nxt = part_r ? ST_DONE : ST_PART;
        else if (span_skip) state_nxt = ST_NEXT;
        else                state_nxt = ST_OP;
      end
      ST_PIX:  if (!pix_issue && !pv_r) state_nxt = ST_NEXT;
      ST_NEXT: state_nxt = ST_ROW;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      level_en_r  <= 1'b0;
      clr_idx_r   <= '0;
      clr_color_r <= 1'b1;
      clr_depth_r <= 1'b1;
      clr_cmd_r   <= 1'b0;
      clr_val_r   <= '0;
      op_go_r     <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        vx_r[i] <= '0;
        vy_r[i] <= '0;
        vz_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      op_go_r <= (state_nxt == ST_OP) && ((state_r != ST_OP) || md_rsp.done);
      pv_r    <= pix_issue;
      if (cfg_wr_en) begin
        level_en_r <= cfg_wr_data;
      end
      if (state_r == ST_CLEAR) begin
        clr_idx_r <= clr_last ? '0 : clr_idx_r + AddrW'(1);
      end
      if (in_acc) begin
        case (in_cmd)
          CMD_LOAD: begin
            if (in_slot != 2'd3) begin
              vx_r[in_slot] <= in_x;
              vy_r[in_slot] <= in_y;
              vz_r[in_slot] <= in_z;
            end
          end
          CMD_CLEAR: begin
            clr_color_r <= 1'b0;
            clr_depth_r <= 1'b1;
            clr_cmd_r   <= 1'b1;
          end
          CMD_FILL: begin
            clr_color_r <= 1'b1;
            clr_depth_r <= 1'b0;
            clr_cmd_r   <= 1'b1;
            clr_val_r   <= in_fc;
          end
          default: begin
            clr_cmd_r <= clr_cmd_r;
          end
        endcase
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cnt_r        <= '0;
      skip_r       <= (in_cmd == CMD_DRAW) && (in_fc == '0);
      res_color_r  <= '0;
      res_depth_r  <= '0;
      rd_ok_r      <= 32'(in_pix) < 32'(StoreSize);
      sort_step_r  <= '0;
      part_r       <= 1'b0;
      draw_color_r <= level_en_r ? {in_fc[7:4], lo_sat} : in_fc;
      for (int i = 0; i < 3; i++) begin
        wx_r[i] <= vx_r[i];
        wy_r[i] <= vy_r[i];
        wz_r[i] <= vz_r[i];
      end
    end

    unique case (state_r)
      ST_READ: begin
        res_color_r <= rd_ok_r ? col_rdata : '0;
        res_depth_r <= rd_ok_r ? dep_rdata : '0;
      end
      ST_SORT: begin
        sort_step_r <= sort_step_r + 2'd1;
        if (wy_r[sp] > wy_r[sq]) begin
          wx_r[sp] <= wx_r[sq];  wx_r[sq] <= wx_r[sp];
          wy_r[sp] <= wy_r[sq];  wy_r[sq] <= wy_r[sp];
          wz_r[sp] <= wz_r[sq];  wz_r[sq] <= wz_r[sp];
        end
      end
      ST_CHECK: begin
        skip_r <= reject;
        op_r   <= OP_SX02;
      end
      ST_PART: begin
        op_r <= OP_SXA;
        if (!part_r) begin
          r_r    <= up_first;
          last_r <= up_last;
          if (up_first > up_last) begin
            part_r <= 1'b1;
          end
        end else begin
          r_r    <= smax0(cy1);
          last_r <= smin(cy2 - ROW_W'(1), HeightS - ROW_W'(1));
        end
      end
      ST_OP: begin
        if (md_rsp.done) begin
          case (op_r)
            OP_SX02: begin
              sx02_r <= md_rsp.result;
              op_r   <= OP_SZ02;
            end
            OP_SZ02: sz02_r <= md_rsp.result;
            OP_SXA: begin
              sxa_r <= md_rsp.result;
              op_r  <= OP_SZA;
            end
            OP_SZA: begin
              sza_r <= md_rsp.result;
              op_r  <= OP_AX;
            end
            OP_AX: begin
              ax_r <= (ARITH_W'(part_r ? wx_r[1] : wx_r[0]) <<< 12)
                      + shr_trunc(md_rsp.result, 4);
              op_r <= OP_AZ;
            end
            OP_AZ: begin
              az_r <= (ARITH_W'(part_r ? wz_r[1] : wz_r[0]) <<< 16)
                      + shr_trunc(md_rsp.result, 4);
              op_r <= OP_BX;
            end
            OP_BX: begin
              bx_r <= (ARITH_W'(wx_r[0]) <<< 12) + shr_trunc(md_rsp.result, 4);
              op_r <= OP_BZ;
            end
            OP_BZ: begin
              bz_r   <= (ARITH_W'(wz_r[0]) <<< 16) + shr_trunc(md_rsp.result, 4);
              // upper half looks one row ahead, lower half at the start row
              swap_r <= part_r ? (ax_r > bx_r) : ((ax_r + sxa_r) > (bx_r + sx02_r));
            end
            OP_DZS: begin
              dzs_r <= md_rsp.result;
              op_r  <= OP_ZST;
            end
            OP_ZST: begin
              zacc_r <= span_za + shr_trunc(md_rsp.result, 16);
              idx_r  <= AddrW'(32'(r_r[ROW_W-2:0]) * 32'(SCREEN_WIDTH) + 32'(col_r));
            end
            default: op_r <= op_r;
          endcase
        end
      end
      ST_ROW: begin
        col_r   <= ColW'(start_s);
        right_r <= ColW'(right_s);
        op_r    <= OP_DZS;
        if (row_end) begin
          part_r <= 1'b1;
        end
      end
      ST_PIX: begin
        if (pix_issue) begin
          col_r  <= col_r + ColW'(1);
          idx_r  <= idx_r + AddrW'(1);
          zacc_r <= zacc_r + dzs_r;
        end
      end
      ST_NEXT: begin
        ax_r <= ax_r + sxa_r;
        az_r <= az_r + sza_r;
        bx_r <= bx_r + sx02_r;
        bz_r <= bz_r + sz02_r;
        r_r  <= r_r + ROW_W'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_r <= {skip_r, cnt_r, res_depth_r, res_color_r};
        end
      end
      default: begin
        op_r <= op_r;
      end
    endcase

    // compare stage payload
    paddr_r <= idx_r;
    pd_r    <= dsum[31:16];
    pok_r   <= dsum[63:32] == '0;
    if (pass && (cnt_r != COUNT_MAX)) begin
      cnt_r <= cnt_r + COUNT_W'(1);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------- checks
  a_pix_stage_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (state_r == ST_PIX))
    else $error("depth compare stage active outside a span");

  a_unit_idle_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !md_rsp.busy)
    else $error("mul/div unit busy while taking a new command");

  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_cmd == CMD_READ)) |=> (state_r == ST_READ))
    else $error("pixel read not captured in the next cycle");

  a_store_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    (col_we && (state_r != ST_CLEAR)) |-> $past(pix_issue) || $past(state_r == ST_PIX))
    else $error("color store written outside clear sweep or pixel pass");

endmodule
